// File: hdl/bba_pkg.sv
// Shared types and codes for the bump block allocator.
// Standalone package; used by bump_block_allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int ADDR_W   = 20;
    localparam int SIZE_W   = 21;
    localparam int STATUS_W = 3;
    localparam int END_W    = 22;   // base + length never exceeds 2^22

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_REALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

    // One row of the block table as stored in RAM.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] length;
    } entry_t;

endpackage

`default_nettype wire

// File: hdl/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/bump_block_allocator.sv
// Top level of the bump block allocator: table scan, decision and write-back.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
`default_nettype none

// Bump allocator over a managed memory of MEMORY_BYTES bytes. Each input word
// is one request (alloc, realloc or free); each request gives exactly one
// result word. Live blocks are kept in a table of TABLE_ENTRIES rows (base and
// length) held in a synchronous RAM; per-row valid bits sit in flip-flops and
// clear at reset, so no clearing pass is needed. Between one acceptance and
// the next, the RAM's single read port walks every row once (one read per
// row, then the latency of its registered read data), the decide state
// writes the table back, and the idle state takes the next word. During the
// walk the block finds the row that matches block_address, the live block
// with the highest base and the lowest free row. New blocks go right after
// the highest live block; nothing is ever compacted. A result waits in the
// output register while the next request is already scanned; the decide
// step holds only while that register is full and stalled. The byte copy
// for a growing realloc is reported through copy_from and copy_length and
// left to outside logic.

module bump_block_allocator #(
    parameter longint unsigned MEMORY_BYTES  = 64'd1048576,
    parameter int              TABLE_ENTRIES = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   command,
    input  wire logic                         address_present,
    input  wire logic [bba_pkg::ADDR_W-1:0]   block_address,
    input  wire logic [bba_pkg::SIZE_W-1:0]   request_size,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              result_null,
    output logic      [bba_pkg::ADDR_W-1:0]   result_address,
    output logic      [bba_pkg::ADDR_W-1:0]   copy_from,
    output logic      [bba_pkg::SIZE_W-1:0]   copy_length,
    output logic      [bba_pkg::STATUS_W-1:0] status
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int LIMIT_W = 34;
    localparam logic [LIMIT_W-1:0] MEM_LIMIT = LIMIT_W'(MEMORY_BYTES);
    localparam logic [CNT_W-1:0]   ROW_COUNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Latched request
    logic [1:0]                 cmd_reg;
    logic                       present_reg;
    logic [bba_pkg::ADDR_W-1:0] addr_reg;
    logic [bba_pkg::SIZE_W-1:0] size_reg;

    // Scan walk
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             pend_vld_reg;
    logic [IDX_W-1:0] pend_idx_reg;

    // Scan findings
    logic                       found_reg;
    logic [IDX_W-1:0]           match_idx_reg;
    logic [bba_pkg::ADDR_W-1:0] match_base_reg;
    logic [bba_pkg::SIZE_W-1:0] match_len_reg;
    logic                       any_reg;
    logic [bba_pkg::ADDR_W-1:0] top_base_reg;
    logic [bba_pkg::END_W-1:0]  top_end_reg;
    logic                       slot_found_reg;
    logic [IDX_W-1:0]           slot_idx_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    // Output register
    logic                         out_valid_reg;
    logic                         rnull_reg, rnull_next;
    logic [bba_pkg::ADDR_W-1:0]   raddr_reg, raddr_next;
    logic [bba_pkg::ADDR_W-1:0]   cfrom_reg, cfrom_next;
    logic [bba_pkg::SIZE_W-1:0]   clen_reg, clen_next;
    logic [bba_pkg::STATUS_W-1:0] status_reg, status_next;

    // RAM port
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    bba_pkg::entry_t       ram_wdata;
    bba_pkg::entry_t       ram_rdata;

    logic in_take;
    logic out_take;
    logic decide_go;
    logic scan_issue;
    logic row_valid;
    logic [bba_pkg::END_W-1:0] row_end;

    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign decide_go  = (state_reg == ST_DECIDE) && (!out_valid_reg || !out_stall);
    assign scan_issue = (state_reg == ST_SCAN) && (scan_cnt_reg < ROW_COUNT);
    assign row_valid  = valid_reg[pend_idx_reg];
    assign row_end    = bba_pkg::END_W'(ram_rdata.base) + bba_pkg::END_W'(ram_rdata.length);

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_null    = rnull_reg;
    assign result_address = raddr_reg;
    assign copy_from      = cfrom_reg;
    assign copy_length    = clen_reg;
    assign status         = status_reg;

    bba_ram #(
        .WIDTH ($bits(bba_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Sequencer: idle -> scan every row -> decide and write back.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Leave once the last row's read data has been folded in.
                if (!scan_issue && pend_vld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (decide_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Decision: build the result word and the table update from the findings.
    always_comb
    begin
        logic                       use_match;
        logic [LIMIT_W-1:0]         new_end;
        logic [bba_pkg::STATUS_W-1:0] place_status;

        use_match    = (cmd_reg == bba_pkg::CMD_REALLOC) && present_reg && found_reg;
        new_end      = LIMIT_W'(top_end_reg) + LIMIT_W'(size_reg);

        if (size_reg == '0)
        begin
            place_status = bba_pkg::STATUS_ZERO;
        end
        else if (new_end > MEM_LIMIT)
        begin
            place_status = bba_pkg::STATUS_NO_ROOM;
        end
        else if (!slot_found_reg)
        begin
            place_status = bba_pkg::STATUS_FULL;
        end
        else
        begin
            place_status = bba_pkg::STATUS_OK;
        end

        rnull_next       = 1'b1;
        raddr_next       = '0;
        cfrom_next       = '0;
        clen_next        = '0;
        status_next      = bba_pkg::STATUS_OK;
        valid_next       = valid_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_idx_reg;
        ram_wdata.base   = top_end_reg[bba_pkg::ADDR_W-1:0];
        ram_wdata.length = size_reg;

        if (cmd_reg == bba_pkg::CMD_FREE)
        begin
            if (present_reg)
            begin
                if (found_reg)
                begin
                    valid_next[match_idx_reg] = 1'b0;
                end
                else
                begin
                    status_next = bba_pkg::STATUS_NOT_FOUND;
                end
            end
        end
        else if (cmd_reg == bba_pkg::CMD_ALLOC || cmd_reg == bba_pkg::CMD_REALLOC)
        begin
            if (!use_match)
            begin
                // Plain allocation
                status_next = place_status;
                if (place_status == bba_pkg::STATUS_OK)
                begin
                    rnull_next               = 1'b0;
                    raddr_next               = top_end_reg[bba_pkg::ADDR_W-1:0];
                    ram_we                   = 1'b1;
                    valid_next[slot_idx_reg] = 1'b1;
                end
            end
            else if (size_reg == '0)
            begin
                // Realloc to zero drops the block
                valid_next[match_idx_reg] = 1'b0;
                status_next               = bba_pkg::STATUS_ZERO;
            end
            else if (size_reg <= match_len_reg)
            begin
                // Shrink in place: rewrite the length only
                rnull_next     = 1'b0;
                raddr_next     = match_base_reg;
                ram_we         = 1'b1;
                ram_waddr      = match_idx_reg;
                ram_wdata.base = match_base_reg;
            end
            else
            begin
                // Grow: new block, copy descriptor, drop the old row
                status_next = place_status;
                if (place_status == bba_pkg::STATUS_OK)
                begin
                    rnull_next                = 1'b0;
                    raddr_next                = top_end_reg[bba_pkg::ADDR_W-1:0];
                    cfrom_next                = match_base_reg;
                    clen_next                 = match_len_reg;
                    ram_we                    = 1'b1;
                    valid_next[slot_idx_reg]  = 1'b1;
                    valid_next[match_idx_reg] = 1'b0;
                end
            end
        end

        // Hold the table until the result can be handed over.
        if (!decide_go)
        begin
            ram_we     = 1'b0;
            valid_next = valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            scan_cnt_reg  <= '0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;

            if (decide_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_take)
            begin
                scan_cnt_reg <= '0;
                pend_vld_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                pend_vld_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Request latch, scan findings and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg        <= command;
            present_reg    <= address_present;
            addr_reg       <= block_address;
            size_reg       <= request_size;
            found_reg      <= 1'b0;
            any_reg        <= 1'b0;
            slot_found_reg <= 1'b0;
            top_end_reg    <= '0;
        end
        else if (state_reg == ST_SCAN && pend_vld_reg)
        begin
            if (row_valid)
            begin
                // First live row with the given base
                if (!found_reg && ram_rdata.base == addr_reg)
                begin
                    found_reg      <= 1'b1;
                    match_idx_reg  <= pend_idx_reg;
                    match_base_reg <= ram_rdata.base;
                    match_len_reg  <= ram_rdata.length;
                end
                // Live row with the highest base
                if (!any_reg || ram_rdata.base > top_base_reg)
                begin
                    any_reg      <= 1'b1;
                    top_base_reg <= ram_rdata.base;
                    top_end_reg  <= row_end;
                end
            end
            else if (!slot_found_reg)
            begin
                slot_found_reg <= 1'b1;
                slot_idx_reg   <= pend_idx_reg;
            end
        end

        if (scan_issue)
        begin
            pend_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        end

        if (decide_go)
        begin
            rnull_reg  <= rnull_next;
            raddr_reg  <= raddr_next;
            cfrom_reg  <= cfrom_next;
            clen_reg   <= clen_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire
